[design/mbrpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR partition table parser package
// Shared types and constants for the sector 0 table parser.
// ----------------------------------------------------------------------------
package mbrpt_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int NUM_LANES  = 10;
    localparam int SLOT_W     = 2;
    localparam int OFFSET_W   = 4;
    localparam int LANE_W     = 4;

    localparam logic [8:0] TABLE_BASE  = 9'd446;
    localparam logic [8:0] TABLE_END   = 9'd510;
    localparam logic [8:0] SIG_POS_LOW = 9'd510;
    localparam logic [8:0] SIG_POS_HIGH = 9'd511;
    localparam logic [7:0] SIG_LOW     = 8'h55;
    localparam logic [7:0] SIG_HIGH    = 8'hAA;

    localparam logic [LANE_W-1:0] LANE_BOOT  = 4'd0;
    localparam logic [LANE_W-1:0] LANE_TYPE  = 4'd1;
    localparam logic [LANE_W-1:0] LANE_START = 4'd2;
    localparam logic [LANE_W-1:0] LANE_LEN   = 4'd6;

    localparam logic [1:0] ST_USABLE = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_NO_SIG = 2'd2;

    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          data;
    } t_wr_req;

    typedef struct packed {
        logic [7:0]  boot;
        logic [7:0]  ptype;
        logic [31:0] start;
        logic [31:0] len;
    } t_entry;

endpackage

[design/mbrpt_entry_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR table entry store
// Four-row byte-lane memory, one lane written per request, registered row read.
// ----------------------------------------------------------------------------
module mbrpt_entry_store (
    input  logic                                i_clk,
    input  mbrpt_pkg::t_wr_req                  i_wr,
    input  logic                                i_rd_en,
    input  logic [mbrpt_pkg::SLOT_W-1:0]        i_rd_addr,
    output mbrpt_pkg::t_entry                   o_rd_data
);
    import mbrpt_pkg::*;

    logic [7:0]        r_mem [NUM_SLOTS][NUM_LANES];
    t_entry            r_rd_data;
    logic              w_lane_en;
    logic [LANE_W-1:0] w_lane;

    always_comb begin
        w_lane_en = 1'b1;
        w_lane    = LANE_BOOT;
        case (i_wr.offset) inside
            4'd0: begin
                w_lane = LANE_BOOT;
            end
            4'd4: begin
                w_lane = LANE_TYPE;
            end
            [4'd8:4'd11]: begin
                w_lane = LANE_START + {2'b00, i_wr.offset[1:0]};
            end
            [4'd12:4'd15]: begin
                w_lane = LANE_LEN + {2'b00, i_wr.offset[1:0]};
            end
            default: begin
                w_lane_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_lane_en) begin
            r_mem[i_wr.slot][w_lane] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data.boot  <= r_mem[i_rd_addr][0];
            r_rd_data.ptype <= r_mem[i_rd_addr][1];
            r_rd_data.start <= {r_mem[i_rd_addr][5], r_mem[i_rd_addr][4],
                                r_mem[i_rd_addr][3], r_mem[i_rd_addr][2]};
            r_rd_data.len   <= {r_mem[i_rd_addr][9], r_mem[i_rd_addr][8],
                                r_mem[i_rd_addr][7], r_mem[i_rd_addr][6]};
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/mbr_partition_table_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR partition table parser
// Bytes 0..510 of sector 0 are taken one per cycle. Byte 511 stalls the input
// until all results of the sector are loaded into the output register: a missing
// signature loads one flag result; otherwise a check pass reads the four
// entries from the entry store (a read state and an evaluate state per slot),
// then each usable entry passes a read state and a load state, or one flag
// result is loaded if none is usable; output stalls lengthen the hold. A sync reset
// clears control state, position, signature byte, capacity and output valid.
// ----------------------------------------------------------------------------
module mbr_partition_table_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_sector_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_slot_index,
    output logic [7:0]  o_part_type,
    output logic [7:0]  o_boot_flag,
    output logic [31:0] o_start_lba,
    output logic [31:0] o_sector_count,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);
    import mbrpt_pkg::*;

    typedef enum logic [2:0] {
        S_RX,
        S_CHK_RD,
        S_CHK_EV,
        S_EMIT_RD,
        S_EMIT_LD,
        S_FLAG
    } t_state;

    t_state              r_state, n_state;
    logic [8:0]          r_pos, n_pos;
    logic [7:0]          r_sig_low, n_sig_low;
    logic [63:0]         r_cap, n_cap;
    logic [SLOT_W-1:0]   r_cnt, n_cnt;
    logic [NUM_SLOTS-1:0] r_mask, n_mask;
    logic [1:0]          r_flag, n_flag;

    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status, n_out_status;
    logic [1:0]          r_out_slot, n_out_slot;
    logic [7:0]          r_out_type, n_out_type;
    logic [7:0]          r_out_boot, n_out_boot;
    logic [31:0]         r_out_start, n_out_start;
    logic [31:0]         r_out_count, n_out_count;
    logic                r_out_last, n_out_last;

    t_wr_req             w_wr;
    logic                w_rd_en;
    logic [SLOT_W-1:0]   w_rd_addr;
    t_entry              w_rd_data;
    logic                w_in_acc;
    logic                w_out_free;
    logic [8:0]          w_rel;
    logic [32:0]         w_end;
    logic                w_usable;
    logic [SLOT_W-1:0]   w_first;
    logic [NUM_SLOTS-1:0] w_rest;

    function automatic logic [SLOT_W-1:0] lowest_set(input logic [NUM_SLOTS-1:0] m);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (m[k]) begin
                idx = SLOT_W'(k);
            end
        end
        return idx;
    endfunction

    mbrpt_entry_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_in_stall  = (r_state != S_RX);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && (r_state == S_RX);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_rel       = r_pos - TABLE_BASE;
    assign w_end       = {1'b0, w_rd_data.start} + {1'b0, w_rd_data.len};
    assign w_usable    = (w_rd_data.ptype != 8'd0) && (w_rd_data.len != 32'd0)
                         && ({31'd0, w_end} <= r_cap);
    assign w_first     = lowest_set(r_mask);
    assign w_rest      = r_mask & ~(NUM_SLOTS'(1) << r_cnt);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_sig_low    = r_sig_low;
        n_cap        = r_cap;
        n_cnt        = r_cnt;
        n_mask       = r_mask;
        n_flag       = r_flag;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_type   = r_out_type;
        n_out_boot   = r_out_boot;
        n_out_start  = r_out_start;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;

        w_wr.en      = 1'b0;
        w_wr.slot    = w_rel[5:4];
        w_wr.offset  = w_rel[3:0];
        w_wr.data    = i_sector_byte;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_cnt;

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_RX: begin
                if (w_in_acc) begin
                    n_pos = r_pos + 9'd1;
                    if (r_pos >= TABLE_BASE && r_pos < TABLE_END) begin
                        w_wr.en = 1'b1;
                    end
                    if (r_pos == SIG_POS_LOW) begin
                        n_sig_low = i_sector_byte;
                    end
                    if (r_pos == SIG_POS_HIGH) begin
                        if (r_sig_low == SIG_LOW && i_sector_byte == SIG_HIGH) begin
                            n_cnt   = '0;
                            n_mask  = '0;
                            n_state = S_CHK_RD;
                        end else begin
                            n_flag  = ST_NO_SIG;
                            n_state = S_FLAG;
                        end
                    end
                end
            end
            S_CHK_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_cnt;
                n_state   = S_CHK_EV;
            end
            S_CHK_EV: begin
                n_mask[r_cnt] = w_usable;
                if (&r_cnt) begin
                    if (n_mask == '0) begin
                        n_flag  = ST_NONE;
                        n_state = S_FLAG;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    n_cnt   = r_cnt + SLOT_W'(1);
                    n_state = S_CHK_RD;
                end
            end
            S_EMIT_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_first;
                n_cnt     = w_first;
                n_state   = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_USABLE;
                    n_out_slot   = r_cnt;
                    n_out_type   = w_rd_data.ptype;
                    n_out_boot   = w_rd_data.boot;
                    n_out_start  = w_rd_data.start;
                    n_out_count  = w_rd_data.len;
                    n_out_last   = (w_rest == '0);
                    n_mask       = w_rest;
                    n_state      = (w_rest == '0) ? S_RX : S_EMIT_RD;
                end
            end
            S_FLAG: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_flag;
                    n_out_slot   = '0;
                    n_out_type   = '0;
                    n_out_boot   = '0;
                    n_out_start  = '0;
                    n_out_count  = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_RX;
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RX;
            r_pos       <= '0;
            r_sig_low   <= '0;
            r_cap       <= '0;
            r_cnt       <= '0;
            r_mask      <= '0;
            r_flag      <= ST_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_sig_low   <= n_sig_low;
            r_cap       <= n_cap;
            r_cnt       <= n_cnt;
            r_mask      <= n_mask;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
        end
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_type   <= n_out_type;
        r_out_boot   <= n_out_boot;
        r_out_start  <= n_out_start;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_index   = r_out_slot;
    assign o_part_type    = r_out_type;
    assign o_boot_flag    = r_out_boot;
    assign o_start_lba    = r_out_start;
    assign o_sector_count = r_out_count;
    assign o_last         = r_out_last;

    a_no_rx_mid_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !(r_out_valid && !r_out_last))
        else $error("byte request taken while sector results pending");

    a_usable_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_USABLE) |->
            (r_out_type != 8'd0 && r_out_count != 32'd0))
        else $error("usable result with zero type or length");

    a_flag_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_USABLE) |->
            (r_out_last && r_out_slot == 2'd0 && r_out_start == 32'd0))
        else $error("flag result not final or not cleared");

endmodule
